FILE: design/ptem_pkg.sv
// Shared types, constants and the glyph slot mapping for the text extent measure.
// No dependencies.
package ptem_pkg;

   localparam int GLYPH_SLOTS_DEF = 71;
   localparam int COUNT_BITS_DEF  = 16;
   localparam int OUT_BITS        = 16;
   localparam int SLOT_BITS       = 7;
   localparam int MARK_COUNT      = 9;

   localparam logic [SLOT_BITS-1:0] DIGIT_SLOT_BASE = 7'd0;
   localparam logic [SLOT_BITS-1:0] LOWER_SLOT_BASE = 7'd10;
   localparam logic [SLOT_BITS-1:0] UPPER_SLOT_BASE = 7'd36;
   localparam logic [SLOT_BITS-1:0] MARK_SLOT_BASE  = 7'd62;
   localparam logic [SLOT_BITS-1:0] FALLBACK_SLOT   = 7'd70;

   localparam logic [7:0] NEWLINE_CODE         = 8'd10;
   localparam logic [7:0] DEFAULT_WIDTH        = 8'd8;
   localparam logic [7:0] DEFAULT_GLYPH_HEIGHT = 8'd8;

   // ( ) + - , : . ! space
   localparam logic [7:0] MARK_CODES [MARK_COUNT] = '{
      8'h28, 8'h29, 8'h2B, 8'h2D, 8'h2C, 8'h3A, 8'h2E, 8'h21, 8'h20
   };

   typedef enum logic [1:0] {
      OP_WIDTH_WR = 2'd0,
      OP_BASE_WR  = 2'd1,
      OP_CHAR     = 2'd2,
      OP_END      = 2'd3
   } op_type;

   typedef struct packed {
      op_type             op;
      logic               newline;
      logic [7:0]         width;
      logic signed [7:0]  baseline;
   } stage_type;

   function automatic logic [SLOT_BITS-1:0] glyph_slot_of(input logic [7:0] code);
      logic [SLOT_BITS-1:0] slot;
      slot = FALLBACK_SLOT;
      for (int i = 0; i < MARK_COUNT; i++) begin
         if (code == MARK_CODES[i]) begin
            slot = MARK_SLOT_BASE + SLOT_BITS'(i);
         end
      end
      if (code >= 8'h30 && code <= 8'h39) begin
         slot = DIGIT_SLOT_BASE + SLOT_BITS'(code - 8'h30);
      end else if (code >= 8'h61 && code <= 8'h7A) begin
         slot = LOWER_SLOT_BASE + SLOT_BITS'(code - 8'h61);
      end else if (code >= 8'h41 && code <= 8'h5A) begin
         slot = UPPER_SLOT_BASE + SLOT_BITS'(code - 8'h41);
      end
      return slot;
   endfunction

endpackage

FILE: design/ptem_glyph_tables.sv
// Width and baseline tables: synchronous memories with per-entry valid bits.
// Depends on ptem_pkg.
module ptem_glyph_tables import ptem_pkg::*; #(
   parameter int GLYPH_SLOTS = GLYPH_SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic [1:0]        op,
   input  logic [7:0]        char_code,
   input  logic signed [8:0] entry_value,
   output stage_type         stage,
   output logic signed [7:0] space_baseline
);

   localparam int SlotW = $clog2(GLYPH_SLOTS);

   logic [7:0] width_mem [GLYPH_SLOTS];
   logic [7:0] base_mem  [GLYPH_SLOTS];

   logic [GLYPH_SLOTS-1:0] width_vld_ff, width_vld_in;
   logic [GLYPH_SLOTS-1:0] base_vld_ff, base_vld_in;
   logic signed [7:0]      space_base_ff, space_base_in;

   logic [7:0]        width_rd_ff;
   logic [7:0]        base_rd_ff;
   logic              width_hit_ff;
   logic              base_hit_ff;
   op_type            op_ff;
   logic              newline_ff;

   op_type            op_cur;
   logic [SlotW-1:0]  slot;
   logic [7:0]        width_wr;
   logic [7:0]        base_wr;
   logic              width_we;
   logic              base_we;

   always_comb begin
      op_cur   = op_type'(op);
      slot     = SlotW'(glyph_slot_of(char_code));
      width_we = enable && (op_cur == OP_WIDTH_WR);
      base_we  = enable && (op_cur == OP_BASE_WR);
      width_wr = entry_value[8] ? 8'd0 : entry_value[7:0];
      if (entry_value > 9'sd127) begin
         base_wr = 8'h7F;
      end else if (entry_value < -9'sd128) begin
         base_wr = 8'h80;
      end else begin
         base_wr = entry_value[7:0];
      end
   end

   always_comb begin
      width_vld_in  = width_vld_ff;
      base_vld_in   = base_vld_ff;
      space_base_in = space_base_ff;
      if (width_we) begin
         width_vld_in[slot] = 1'b1;
      end
      if (base_we) begin
         base_vld_in[slot] = 1'b1;
         if (slot == SlotW'(FALLBACK_SLOT)) begin
            space_base_in = base_wr;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_vld_ff  <= '0;
         base_vld_ff   <= '0;
         space_base_ff <= '0;
      end else begin
         width_vld_ff  <= width_vld_in;
         base_vld_ff   <= base_vld_in;
         space_base_ff <= space_base_in;
      end
   end

   always_ff @(posedge clock) begin
      if (width_we) begin
         width_mem[slot] <= width_wr;
      end
      if (base_we) begin
         base_mem[slot] <= base_wr;
      end
   end

   // registered read, taken with the item
   always_ff @(posedge clock) begin
      if (enable) begin
         width_rd_ff  <= width_mem[slot];
         base_rd_ff   <= base_mem[slot];
         width_hit_ff <= width_vld_ff[slot];
         base_hit_ff  <= base_vld_ff[slot];
         op_ff        <= op_cur;
         newline_ff   <= (char_code == NEWLINE_CODE);
      end
   end

   always_comb begin
      stage.op       = op_ff;
      stage.newline  = newline_ff;
      stage.width    = width_hit_ff ? width_rd_ff : DEFAULT_WIDTH;
      stage.baseline = base_hit_ff ? base_rd_ff : 8'sd0;
      space_baseline = space_base_ff;
   end

endmodule

FILE: design/ptem_line_accum.sv
// Per-string line accumulators; produces the registered end-of-string record.
// Depends on ptem_pkg.
module ptem_line_accum import ptem_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  stage_vld,
   input  stage_type             stage,
   input  logic signed [7:0]     space_baseline,
   output logic                  fin_vld,
   output logic [COUNT_BITS-1:0] fin_lines,
   output logic [COUNT_BITS-1:0] fin_longest,
   output logic [COUNT_BITS-1:0] fin_widest,
   output logic signed [9:0]     fin_diff
);

   logic [COUNT_BITS-1:0] line_chars_ff, line_chars_in;
   logic [COUNT_BITS-1:0] longest_ff, longest_in;
   logic [COUNT_BITS-1:0] line_pix_ff, line_pix_in;
   logic [COUNT_BITS-1:0] widest_ff, widest_in;
   logic [COUNT_BITS-1:0] nl_count_ff, nl_count_in;
   logic                  any_seen_ff, any_seen_in;
   logic signed [7:0]     line_min_ff, line_min_in;
   logic signed [7:0]     line_max_ff, line_max_in;
   logic                  started_ff, started_in;
   logic signed [7:0]     top_ff, top_in;
   logic                  closed_ff, closed_in;

   logic                  fin_vld_ff, fin_vld_in;
   logic [COUNT_BITS-1:0] fin_lines_ff, fin_lines_in;
   logic [COUNT_BITS-1:0] fin_longest_ff, fin_longest_in;
   logic [COUNT_BITS-1:0] fin_widest_ff, fin_widest_in;
   logic signed [9:0]     fin_diff_ff, fin_diff_in;

   // line close values
   logic signed [7:0]     eff_min;
   logic signed [7:0]     eff_max;
   logic [COUNT_BITS-1:0] cl_longest;
   logic [COUNT_BITS-1:0] cl_widest;
   logic signed [7:0]     cl_top;
   logic                  work;

   function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                     input logic [7:0] b);
      logic [COUNT_BITS:0] s;
      s = {1'b0, a} + (COUNT_BITS+1)'(b);
      return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
   endfunction

   always_comb begin
      eff_min    = started_ff ? line_min_ff : space_baseline;
      eff_max    = started_ff ? line_max_ff : space_baseline;
      cl_longest = (line_chars_ff > longest_ff) ? line_chars_ff : longest_ff;
      cl_widest  = (line_pix_ff > widest_ff) ? line_pix_ff : widest_ff;
      cl_top     = closed_ff ? top_ff : eff_max;
      work       = advance && stage_vld;
   end

   always_comb begin
      line_chars_in  = line_chars_ff;
      longest_in     = longest_ff;
      line_pix_in    = line_pix_ff;
      widest_in      = widest_ff;
      nl_count_in    = nl_count_ff;
      any_seen_in    = any_seen_ff;
      line_min_in    = line_min_ff;
      line_max_in    = line_max_ff;
      started_in     = started_ff;
      top_in         = top_ff;
      closed_in      = closed_ff;
      fin_vld_in     = advance ? 1'b0 : fin_vld_ff;
      fin_lines_in   = fin_lines_ff;
      fin_longest_in = fin_longest_ff;
      fin_widest_in  = fin_widest_ff;
      fin_diff_in    = fin_diff_ff;
      if (work) begin
         case (stage.op)
            OP_CHAR: begin
               any_seen_in = 1'b1;
               if (stage.newline) begin
                  longest_in    = cl_longest;
                  widest_in     = cl_widest;
                  top_in        = cl_top;
                  closed_in     = 1'b1;
                  nl_count_in   = sat_add(nl_count_ff, 8'd1);
                  line_chars_in = '0;
                  line_pix_in   = '0;
                  started_in    = 1'b0;
                  line_min_in   = '0;
                  line_max_in   = '0;
               end else begin
                  line_chars_in = sat_add(line_chars_ff, 8'd1);
                  line_pix_in   = sat_add(line_pix_ff, stage.width);
                  started_in    = 1'b1;
                  if (!started_ff) begin
                     line_min_in = stage.baseline;
                     line_max_in = stage.baseline;
                  end else begin
                     if (stage.baseline > line_max_ff) begin
                        line_max_in = stage.baseline;
                     end
                     if (stage.baseline < line_min_ff) begin
                        line_min_in = stage.baseline;
                     end
                  end
               end
            end
            OP_END: begin
               fin_vld_in = 1'b1;
               if (any_seen_ff) begin
                  fin_lines_in   = sat_add(nl_count_ff, 8'd1);
                  fin_longest_in = cl_longest;
                  fin_widest_in  = cl_widest;
                  fin_diff_in    = 10'(cl_top) - 10'(eff_min);
               end else begin
                  fin_lines_in   = '0;
                  fin_longest_in = '0;
                  fin_widest_in  = '0;
                  fin_diff_in    = '0;
               end
               line_chars_in = '0;
               longest_in    = '0;
               line_pix_in   = '0;
               widest_in     = '0;
               nl_count_in   = '0;
               any_seen_in   = 1'b0;
               line_min_in   = '0;
               line_max_in   = '0;
               started_in    = 1'b0;
               top_in        = '0;
               closed_in     = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_chars_ff <= '0;
         longest_ff    <= '0;
         line_pix_ff   <= '0;
         widest_ff     <= '0;
         nl_count_ff   <= '0;
         any_seen_ff   <= 1'b0;
         line_min_ff   <= '0;
         line_max_ff   <= '0;
         started_ff    <= 1'b0;
         top_ff        <= '0;
         closed_ff     <= 1'b0;
         fin_vld_ff    <= 1'b0;
      end else begin
         line_chars_ff <= line_chars_in;
         longest_ff    <= longest_in;
         line_pix_ff   <= line_pix_in;
         widest_ff     <= widest_in;
         nl_count_ff   <= nl_count_in;
         any_seen_ff   <= any_seen_in;
         line_min_ff   <= line_min_in;
         line_max_ff   <= line_max_in;
         started_ff    <= started_in;
         top_ff        <= top_in;
         closed_ff     <= closed_in;
         fin_vld_ff    <= fin_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_lines_ff   <= fin_lines_in;
      fin_longest_ff <= fin_longest_in;
      fin_widest_ff  <= fin_widest_in;
      fin_diff_ff    <= fin_diff_in;
   end

   assign fin_vld     = fin_vld_ff;
   assign fin_lines   = fin_lines_ff;
   assign fin_longest = fin_longest_ff;
   assign fin_widest  = fin_widest_ff;
   assign fin_diff    = fin_diff_ff;

endmodule

FILE: design/ptem_extent_out.sv
// Result stage: pixel height product, clamping, saturation and the output register.
// Depends on ptem_pkg.
module ptem_extent_out import ptem_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [7:0]            glyph_height,
   input  logic                  fin_vld,
   input  logic [COUNT_BITS-1:0] fin_lines,
   input  logic [COUNT_BITS-1:0] fin_longest,
   input  logic [COUNT_BITS-1:0] fin_widest,
   input  logic signed [9:0]     fin_diff,
   output logic                  rsp_valid,
   output logic [OUT_BITS-1:0]   width_in_chars,
   output logic [OUT_BITS-1:0]   height_in_chars,
   output logic [OUT_BITS-1:0]   width_in_pixels,
   output logic [OUT_BITS-1:0]   height_in_pixels
);

   localparam int HW      = COUNT_BITS + 10;
   localparam int XW      = COUNT_BITS + OUT_BITS;
   localparam int LimBits = (COUNT_BITS < OUT_BITS) ? COUNT_BITS : OUT_BITS;
   localparam logic [OUT_BITS-1:0] OutLim = OUT_BITS'({LimBits{1'b1}});

   logic                rsp_valid_ff, rsp_valid_in;
   logic [OUT_BITS-1:0] wchars_ff, wchars_in;
   logic [OUT_BITS-1:0] hchars_ff, hchars_in;
   logic [OUT_BITS-1:0] wpix_ff, wpix_in;
   logic [OUT_BITS-1:0] hpix_ff, hpix_in;

   logic [COUNT_BITS+7:0] prod;
   logic signed [HW-1:0]  hsum;

   function automatic logic [OUT_BITS-1:0] out_sat(input logic [COUNT_BITS-1:0] v);
      logic [XW-1:0] x;
      x = XW'(v);
      return (x > XW'(OutLim)) ? OutLim : x[OUT_BITS-1:0];
   endfunction

   always_comb begin
      prod = (COUNT_BITS+8)'(fin_lines) * (COUNT_BITS+8)'(glyph_height);
      hsum = $signed({2'b00, prod}) + HW'(fin_diff);
      rsp_valid_in = advance ? fin_vld : rsp_valid_ff;
      wchars_in = out_sat(fin_longest);
      hchars_in = out_sat(fin_lines);
      wpix_in   = out_sat(fin_widest);
      if (hsum[HW-1]) begin
         hpix_in = '0;
      end else if ($unsigned(hsum) > HW'(OutLim)) begin
         hpix_in = OutLim;
      end else begin
         hpix_in = hsum[OUT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         wchars_ff <= wchars_in;
         hchars_ff <= hchars_in;
         wpix_ff   <= wpix_in;
         hpix_ff   <= hpix_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign width_in_chars   = wchars_ff;
   assign height_in_chars  = hchars_ff;
   assign width_in_pixels  = wpix_ff;
   assign height_in_pixels = hpix_ff;

endmodule

FILE: design/proportional_text_extent_measure.sv
// Top level of the proportional text extent measure.
// Depends on ptem_pkg, ptem_glyph_tables, ptem_line_accum, ptem_extent_out.
//
//   port group  direction  transfer condition
//   req_*       in         req_valid && req_ready
//   rsp_*       out        rsp_valid && rsp_ready
//   csr_*       in         csr_write_enable
//
// One item per cycle unless a result is stalled. Three stages: table read,
// line accumulate, height and saturation, each ending in a register.
// Table writes land at transfer, so the next item sees them without forwarding.
// A stalled result holds the whole pipe; req_ready = !rsp_valid || rsp_ready.
// Synchronous reset; tables read as defaults after reset, no clearing pass.
module proportional_text_extent_measure import ptem_pkg::*; #(
   parameter int GLYPH_SLOTS = GLYPH_SLOTS_DEF,
   parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_op,
   input  logic [7:0]          req_char_code,
   input  logic signed [8:0]   req_entry_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [OUT_BITS-1:0] rsp_width_in_chars,
   output logic [OUT_BITS-1:0] rsp_height_in_chars,
   output logic [OUT_BITS-1:0] rsp_width_in_pixels,
   output logic [OUT_BITS-1:0] rsp_height_in_pixels,
   input  logic                csr_write_enable,
   input  logic [7:0]          csr_write_data
);

   logic [7:0] glyph_height_ff, glyph_height_in;
   logic       stage_vld_ff, stage_vld_in;

   logic                  advance;
   logic                  req_xfer;
   stage_type             stage;
   logic signed [7:0]     space_baseline;
   logic                  fin_vld;
   logic [COUNT_BITS-1:0] fin_lines;
   logic [COUNT_BITS-1:0] fin_longest;
   logic [COUNT_BITS-1:0] fin_widest;
   logic signed [9:0]     fin_diff;

   always_comb begin
      advance         = !rsp_valid || rsp_ready;
      req_ready       = advance;
      req_xfer        = req_valid && advance;
      stage_vld_in    = advance ? req_xfer : stage_vld_ff;
      glyph_height_in = csr_write_enable ? csr_write_data : glyph_height_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         glyph_height_ff <= DEFAULT_GLYPH_HEIGHT;
         stage_vld_ff    <= 1'b0;
      end else begin
         glyph_height_ff <= glyph_height_in;
         stage_vld_ff    <= stage_vld_in;
      end
   end

   ptem_glyph_tables #(
      .GLYPH_SLOTS(GLYPH_SLOTS)
   ) u_tables (
      .clock          (clock),
      .reset          (reset),
      .enable         (req_xfer),
      .op             (req_op),
      .char_code      (req_char_code),
      .entry_value    (req_entry_value),
      .stage          (stage),
      .space_baseline (space_baseline)
   );

   ptem_line_accum #(
      .COUNT_BITS(COUNT_BITS)
   ) u_accum (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .stage_vld      (stage_vld_ff),
      .stage          (stage),
      .space_baseline (space_baseline),
      .fin_vld        (fin_vld),
      .fin_lines      (fin_lines),
      .fin_longest    (fin_longest),
      .fin_widest     (fin_widest),
      .fin_diff       (fin_diff)
   );

   ptem_extent_out #(
      .COUNT_BITS(COUNT_BITS)
   ) u_out (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .glyph_height     (glyph_height_ff),
      .fin_vld          (fin_vld),
      .fin_lines        (fin_lines),
      .fin_longest      (fin_longest),
      .fin_widest       (fin_widest),
      .fin_diff         (fin_diff),
      .rsp_valid        (rsp_valid),
      .width_in_chars   (rsp_width_in_chars),
      .height_in_chars  (rsp_height_in_chars),
      .width_in_pixels  (rsp_width_in_pixels),
      .height_in_pixels (rsp_height_in_pixels)
   );

endmodule

FILE: dv/tb_proportional_text_extent_measure.sv
// Self-checking testbench for proportional_text_extent_measure: a directed stimulus table,
// then random strings over several glyph heights, checked against an in-bench text measurer.
// Depends on ptem_pkg and the design under test only.
`timescale 1ns / 1ps

module tb_proportional_text_extent_measure;
   import ptem_pkg::*;

   localparam int STALL_LIMIT   = 2000;
   localparam int HOLD_CYCLES   = 80;
   localparam int DRAIN_CYCLES  = 8;
   localparam int PHASE_ITEMS   = 185;

   // ( ) + - , : . ! space, in slot order
   localparam logic [7:0] MARK_CHARS [9] = '{
      8'h28, 8'h29, 8'h2B, 8'h2D, 8'h2C, 8'h3A, 8'h2E, 8'h21, 8'h20
   };

   typedef struct packed {
      logic [15:0] width_in_chars;
      logic [15:0] height_in_chars;
      logic [15:0] width_in_pixels;
      logic [15:0] height_in_pixels;
   } extent_type;

   typedef struct {
      op_type            op;
      logic [7:0]        code;
      logic signed [8:0] value;
      bit                typed;
      extent_type        result;
   } stim_row_type;

   logic              clock;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic              req_ready;
   logic [1:0]        req_op           = 2'd0;
   logic [7:0]        req_char_code    = 8'd0;
   logic signed [8:0] req_entry_value  = 9'd0;
   logic              rsp_valid;
   logic              rsp_ready        = 1'b0;
   logic [15:0]       rsp_width_in_chars;
   logic [15:0]       rsp_height_in_chars;
   logic [15:0]       rsp_width_in_pixels;
   logic [15:0]       rsp_height_in_pixels;
   logic              csr_write_enable = 1'b0;
   logic [7:0]        csr_write_data   = 8'd0;

   bit          steady       = 1'b0;
   bit          hold_request = 1'b0;
   bit          hold_done    = 1'b0;
   int unsigned hold_left    = 0;
   int unsigned stall_cycles = 0;
   int          fail_count   = 0;

   extent_type pending_extents [$];

   // measurer state
   logic [7:0]        width_tbl [GLYPH_SLOTS_DEF];
   logic signed [7:0] base_tbl  [GLYPH_SLOTS_DEF];
   logic [7:0]        glyph_h;
   logic [15:0]       cur_chars, max_chars, cur_pix, max_pix, nl_count;
   bit                seen_char, line_open, first_closed;
   int                lo_base, hi_base, first_top;

   proportional_text_extent_measure dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_op               (req_op),
      .req_char_code        (req_char_code),
      .req_entry_value      (req_entry_value),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_width_in_chars   (rsp_width_in_chars),
      .rsp_height_in_chars  (rsp_height_in_chars),
      .rsp_width_in_pixels  (rsp_width_in_pixels),
      .rsp_height_in_pixels (rsp_height_in_pixels),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned slot_for_code(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30) + int'(DIGIT_SLOT_BASE);
      if (c >= 8'h61 && c <= 8'h7A) return int'(c - 8'h61) + int'(LOWER_SLOT_BASE);
      if (c >= 8'h41 && c <= 8'h5A) return int'(c - 8'h41) + int'(UPPER_SLOT_BASE);
      for (int i = 0; i < 9; i++) begin
         if (c == MARK_CHARS[i]) return int'(MARK_SLOT_BASE) + i;
      end
      return int'(FALLBACK_SLOT);
   endfunction

   function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[16] ? 16'hFFFF : s[15:0];
   endfunction

   task automatic clear_string();
      cur_chars    = '0;
      max_chars    = '0;
      cur_pix      = '0;
      max_pix      = '0;
      nl_count     = '0;
      seen_char    = 1'b0;
      line_open    = 1'b0;
      first_closed = 1'b0;
      lo_base      = 0;
      hi_base      = 0;
      first_top    = 0;
   endtask

   task automatic reset_measurer();
      glyph_h = DEFAULT_GLYPH_HEIGHT;
      for (int i = 0; i < GLYPH_SLOTS_DEF; i++) begin
         width_tbl[i] = DEFAULT_WIDTH;
         base_tbl[i]  = '0;
      end
      clear_string();
   endtask

   task automatic fold_line();
      if (!line_open) begin
         lo_base = base_tbl[int'(FALLBACK_SLOT)];
         hi_base = base_tbl[int'(FALLBACK_SLOT)];
      end
      if (cur_chars > max_chars) max_chars = cur_chars;
      if (cur_pix > max_pix) max_pix = cur_pix;
      if (!first_closed) begin
         first_top    = hi_base;
         first_closed = 1'b1;
      end
   endtask

   task automatic measure_item(input op_type op, input logic [7:0] code,
                               input logic signed [8:0] val,
                               output bit produced, output extent_type r);
      int unsigned slot;
      int          b;
      int          h;
      logic [15:0] lines;
      slot     = slot_for_code(code);
      produced = 1'b0;
      r        = '0;
      case (op)
         OP_WIDTH_WR: begin
            width_tbl[slot] = (val < 0) ? 8'd0 : val[7:0];
         end
         OP_BASE_WR: begin
            if (val < -128) base_tbl[slot] = 8'h80;
            else if (val > 127) base_tbl[slot] = 8'h7F;
            else base_tbl[slot] = val[7:0];
         end
         OP_CHAR: begin
            seen_char = 1'b1;
            if (code == NEWLINE_CODE) begin
               fold_line();
               nl_count  = sat_add(nl_count, 16'd1);
               cur_chars = '0;
               cur_pix   = '0;
               line_open = 1'b0;
               lo_base   = 0;
               hi_base   = 0;
            end else begin
               b         = base_tbl[slot];
               cur_chars = sat_add(cur_chars, 16'd1);
               cur_pix   = sat_add(cur_pix, {8'd0, width_tbl[slot]});
               if (!line_open) begin
                  lo_base   = b;
                  hi_base   = b;
                  line_open = 1'b1;
               end else begin
                  if (b > hi_base) hi_base = b;
                  if (b < lo_base) lo_base = b;
               end
            end
         end
         OP_END: begin
            produced = 1'b1;
            if (seen_char) begin
               fold_line();
               lines = sat_add(nl_count, 16'd1);
               h = int'(lines) * int'(glyph_h) + first_top - lo_base;
               if (h < 0) h = 0;
               if (h > 65535) h = 65535;
               r.width_in_chars   = max_chars;
               r.height_in_chars  = lines;
               r.width_in_pixels  = max_pix;
               r.height_in_pixels = h[15:0];
            end
            clear_string();
         end
         default: begin
         end
      endcase
   endtask

   task automatic transfer_item(input op_type op, input logic [7:0] code,
                                input logic signed [8:0] val,
                                input bit typed, input extent_type typed_r);
      bit         produced;
      extent_type r;
      while (!steady && $urandom_range(0, 99) < 22) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= op;
      req_char_code   <= code;
      req_entry_value <= val;
      do @(posedge clock); while (!(req_valid && req_ready));
      measure_item(op, code, val, produced, r);
      if (produced) pending_extents.push_back(typed ? typed_r : r);
   endtask

   function automatic logic [7:0] pick_code();
      int unsigned k;
      k = $urandom_range(0, 99);
      if (k < 18) return NEWLINE_CODE;
      if (k < 33) return 8'($urandom_range(0, 255));
      if (k < 50) return MARK_CHARS[$urandom_range(0, 8)];
      if (k < 62) return 8'h30 + 8'($urandom_range(0, 9));
      if (k < 82) return 8'h61 + 8'($urandom_range(0, 25));
      return 8'h41 + 8'($urandom_range(0, 25));
   endfunction

   task automatic send_table_write();
      transfer_item($urandom_range(0, 1) ? OP_BASE_WR : OP_WIDTH_WR, pick_code(),
                    9'($urandom_range(0, 511)), 1'b0, '0);
   endtask

   // glyph height is sampled late in the pipe: write it only with nothing in flight
   task automatic set_glyph_height(input logic [7:0] v);
      req_valid <= 1'b0;
      while (pending_extents.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      glyph_h = v;
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_random_strings(input int unsigned goal);
      int unsigned sent;
      int unsigned len;
      sent = 0;
      while (sent < goal) begin
         if ($urandom_range(0, 99) < 12) begin
            len = $urandom_range(1, 6);
            repeat (len) begin
               transfer_item(op_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                             9'($urandom_range(0, 511)), 1'b0, '0);
            end
            sent += len;
         end else begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10);
            repeat ($urandom_range(0, 2)) begin
               send_table_write();
               sent++;
            end
            repeat (len) begin
               if ($urandom_range(0, 19) == 0) send_table_write();
               else transfer_item(OP_CHAR, pick_code(), 9'($urandom_range(0, 511)), 1'b0, '0);
               sent++;
            end
            transfer_item(OP_END, 8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)),
                          1'b0, '0);
            sent++;
         end
      end
   endtask

   stim_row_type directed_rows [25] = '{
      '{OP_END,      8'd0,         9'd0,   1'b1, {16'd0, 16'd0, 16'd0, 16'd0}},
      '{OP_CHAR,     "a",          9'd0,   1'b0, 64'd0},
      '{OP_END,      8'd0,         9'd0,   1'b1, {16'd1, 16'd1, 16'd8, 16'd8}},
      '{OP_CHAR,     8'd0,         9'd0,   1'b0, 64'd0},
      '{OP_CHAR,     NEWLINE_CODE, 9'd0,   1'b0, 64'd0},
      '{OP_END,      8'd0,         9'd0,   1'b1, {16'd1, 16'd2, 16'd8, 16'd16}},
      '{OP_WIDTH_WR, "Z",          9'h100, 1'b0, 64'd0},
      '{OP_BASE_WR,  "9",          9'h0FF, 1'b0, 64'd0},
      '{OP_BASE_WR,  NEWLINE_CODE, 9'h100, 1'b0, 64'd0},
      '{OP_WIDTH_WR, 8'hFF,        9'h0FF, 1'b0, 64'd0},
      '{OP_CHAR,     "9",          9'd0,   1'b0, 64'd0},
      '{OP_CHAR,     "Z",          9'd0,   1'b0, 64'd0},
      '{OP_CHAR,     "(",          9'd0,   1'b0, 64'd0},
      '{OP_CHAR,     NEWLINE_CODE, 9'd0,   1'b0, 64'd0},
      '{OP_CHAR,     NEWLINE_CODE, 9'd0,   1'b0, 64'd0},
      '{OP_END,      8'd0,         9'd0,   1'b0, 64'd0},
      '{OP_CHAR,     8'hFF,        9'd0,   1'b0, 64'd0},
      '{OP_BASE_WR,  "z",          9'd100, 1'b0, 64'd0},
      '{OP_CHAR,     "z",          9'd0,   1'b0, 64'd0},
      '{OP_CHAR,     "!",          9'd0,   1'b0, 64'd0},
      '{OP_END,      8'd0,         9'd0,   1'b0, 64'd0},
      '{OP_CHAR,     " ",          9'd0,   1'b0, 64'd0},
      '{OP_CHAR,     NEWLINE_CODE, 9'd0,   1'b0, 64'd0},
      '{OP_CHAR,     "z",          9'd0,   1'b0, 64'd0},
      '{OP_END,      8'd0,         9'd0,   1'b1, {16'd1, 16'd2, 16'd255, 16'd0}}
   };

   initial begin
      logic [7:0] gh;
      reset_measurer();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         transfer_item(directed_rows[i].op, directed_rows[i].code, directed_rows[i].value,
                       directed_rows[i].typed, directed_rows[i].result);
      end

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: gh = 8'd1;
            1: gh = 8'd255;
            2: gh = 8'd0;
            default: gh = 8'($urandom_range(1, 254));
         endcase
         set_glyph_height(gh);
         steady = (p == 3);
         if (p == 0) hold_request <= 1'b1;
         run_random_strings(PHASE_ITEMS);
      end
      steady = 1'b0;

      req_valid <= 1'b0;
      while (pending_extents.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("proportional_text_extent_measure: match");
      end else begin
         $display("proportional_text_extent_measure: mismatch");
      end
      $finish;
   end

   // result side: random stalls, one long hold-off to back up the pipe
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_request && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || ($urandom_range(0, 99) >= 22);
      end
   end

   always @(posedge clock) begin
      extent_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_extents.size() == 0) begin
            $error("unexpected result transfer");
            fail_count++;
         end else begin
            want = pending_extents.pop_front();
            if (rsp_width_in_chars !== want.width_in_chars) begin
               $error("width_in_chars: expected %0d, got %0d",
                      want.width_in_chars, rsp_width_in_chars);
               fail_count++;
            end
            if (rsp_height_in_chars !== want.height_in_chars) begin
               $error("height_in_chars: expected %0d, got %0d",
                      want.height_in_chars, rsp_height_in_chars);
               fail_count++;
            end
            if (rsp_width_in_pixels !== want.width_in_pixels) begin
               $error("width_in_pixels: expected %0d, got %0d",
                      want.width_in_pixels, rsp_width_in_pixels);
               fail_count++;
            end
            if (rsp_height_in_pixels !== want.height_in_pixels) begin
               $error("height_in_pixels: expected %0d, got %0d",
                      want.height_in_pixels, rsp_height_in_pixels);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $error("no transfer for %0d cycles", STALL_LIMIT);
         $display("proportional_text_extent_measure: mismatch");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule

FILE: proportional_text_extent_measure.f
design/ptem_pkg.sv
design/ptem_glyph_tables.sv
design/ptem_line_accum.sv
design/ptem_extent_out.sv
design/proportional_text_extent_measure.sv
dv/tb_proportional_text_extent_measure.sv
